>>> design/pcq_pkg.sv
`timescale 1ns / 1ps
package pcq_pkg;

    typedef enum logic [3:0] {
        ACT_START        = 4'd0,
        ACT_SUBMIT       = 4'd1,
        ACT_CANCEL       = 4'd2,
        ACT_DISPATCH     = 4'd3,
        ACT_FINISH       = 4'd4,
        ACT_MARK_TIMEOUT = 4'd5,
        ACT_STOP_ON      = 4'd6,
        ACT_STOP_OFF     = 4'd7,
        ACT_SHUTDOWN     = 4'd8
    } action_t;

    localparam logic [3:0] EV_ACCEPTED         = 4'd0;
    localparam logic [3:0] EV_REJECTED         = 4'd1;
    localparam logic [3:0] EV_SUPERSEDED       = 4'd2;
    localparam logic [3:0] EV_CANCELLED        = 4'd3;
    localparam logic [3:0] EV_SHUTDOWN_DISCARD = 4'd4;
    localparam logic [3:0] EV_DISPATCHED       = 4'd5;
    localparam logic [3:0] EV_EMPTY            = 4'd6;
    localparam logic [3:0] EV_WORKER_STOPPED   = 4'd7;
    localparam logic [3:0] EV_SUCCEEDED        = 4'd8;
    localparam logic [3:0] EV_FAILED           = 4'd9;
    localparam logic [3:0] EV_ACK              = 4'd10;

    // wide enough for a slot position at the deepest supported level
    localparam int POS_FIELD_BITS = 5;

    typedef enum logic [2:0] {
        LOP_HOLD,
        LOP_APPEND,
        LOP_REPLACE,
        LOP_REMOVE,
        LOP_CLEAR
    } level_op_t;

    typedef struct packed {
        level_op_t                 op;
        logic [POS_FIELD_BITS-1:0] pos;
    } level_ctrl_t;

    typedef struct packed {
        logic load_all;
        logic load_id;
        logic shift;
    } cell_cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SECOND,
        S_DRAIN,
        S_WAIT
    } state_t;

endpackage

>>> design/pcq_cell.sv
`timescale 1ns / 1ps
module pcq_cell
    import pcq_pkg::*;
#(
    parameter int TICKET_BITS = 16,
    parameter int KEY_BITS    = 16,
    parameter int CMP_BITS    = 16
)
(
    input  logic                   clk,
    input  cell_cmd_t              cmd,
    input  logic [TICKET_BITS-1:0] wr_id,
    input  logic [KEY_BITS-1:0]    wr_key,
    input  logic                   wr_kv,
    input  logic [TICKET_BITS-1:0] nb_id,
    input  logic [KEY_BITS-1:0]    nb_key,
    input  logic                   nb_kv,
    input  logic                   occupied,
    input  logic [CMP_BITS-1:0]    cmp_id,
    input  logic [KEY_BITS-1:0]    cmp_key,
    output logic [TICKET_BITS-1:0] id_out,
    output logic [KEY_BITS-1:0]    key_out,
    output logic                   kv_out,
    output logic                   key_hit,
    output logic                   id_hit
);

    logic [TICKET_BITS-1:0] id_reg, id_next;
    logic [KEY_BITS-1:0]    key_reg, key_next;
    logic                   kv_reg, kv_next;

    always_comb
    begin
        id_next  = id_reg;
        key_next = key_reg;
        kv_next  = kv_reg;
        priority if (cmd.load_all)
        begin
            id_next  = wr_id;
            key_next = wr_key;
            kv_next  = wr_kv;
        end
        else if (cmd.load_id)
        begin
            id_next = wr_id;
        end
        else if (cmd.shift)
        begin
            id_next  = nb_id;
            key_next = nb_key;
            kv_next  = nb_kv;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        key_reg <= key_next;
        kv_reg  <= kv_next;
    end

    assign id_out  = id_reg;
    assign key_out = key_reg;
    assign kv_out  = kv_reg;
    assign key_hit = occupied && kv_reg && (key_reg == cmp_key);
    assign id_hit  = occupied && (CMP_BITS'(id_reg) == cmp_id);

endmodule

>>> design/pcq_level.sv
`timescale 1ns / 1ps
module pcq_level
    import pcq_pkg::*;
#(
    parameter int LEVEL_DEPTH = 8,
    parameter int TICKET_BITS = 16,
    parameter int KEY_BITS    = 16,
    parameter int CMP_BITS    = 16
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  level_ctrl_t                          ctrl,
    input  logic [TICKET_BITS-1:0]               wr_id,
    input  logic [KEY_BITS-1:0]                  wr_key,
    input  logic                                 wr_kv,
    input  logic [CMP_BITS-1:0]                  cmp_id,
    input  logic [KEY_BITS-1:0]                  cmp_key,
    output logic [$clog2(LEVEL_DEPTH+1)-1:0]     count,
    output logic [TICKET_BITS-1:0]               ids [LEVEL_DEPTH],
    output logic [LEVEL_DEPTH-1:0]               key_hit,
    output logic [LEVEL_DEPTH-1:0]               id_hit
);

    localparam int CNT_BITS = $clog2(LEVEL_DEPTH + 1);

    logic [CNT_BITS-1:0]    count_reg, count_next;
    logic [KEY_BITS-1:0]    keys [LEVEL_DEPTH];
    logic                   kvs  [LEVEL_DEPTH];
    logic [TICKET_BITS-1:0] nb_ids  [LEVEL_DEPTH];
    logic [KEY_BITS-1:0]    nb_keys [LEVEL_DEPTH];
    logic                   nb_kvs  [LEVEL_DEPTH];
    cell_cmd_t              cmds [LEVEL_DEPTH];

    always_comb
    begin
        unique case (ctrl.op)
            LOP_APPEND: count_next = count_reg + 1'b1;
            LOP_REMOVE: count_next = count_reg - 1'b1;
            LOP_CLEAR:  count_next = '0;
            default:    count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

    for (genvar i = 0; i < LEVEL_DEPTH; i++) begin : g_cell
        if (i < LEVEL_DEPTH - 1) begin : g_nb
            assign nb_ids[i]  = ids[i+1];
            assign nb_keys[i] = keys[i+1];
            assign nb_kvs[i]  = kvs[i+1];
        end
        else begin : g_end
            assign nb_ids[i]  = ids[i];
            assign nb_keys[i] = keys[i];
            assign nb_kvs[i]  = kvs[i];
        end

        assign cmds[i].load_all = (ctrl.op == LOP_APPEND) && (count_reg == CNT_BITS'(i));
        assign cmds[i].load_id  = (ctrl.op == LOP_REPLACE) && (ctrl.pos == POS_FIELD_BITS'(i));
        assign cmds[i].shift    = (ctrl.op == LOP_REMOVE) && (POS_FIELD_BITS'(i) >= ctrl.pos);

        pcq_cell #(
            .TICKET_BITS (TICKET_BITS),
            .KEY_BITS    (KEY_BITS),
            .CMP_BITS    (CMP_BITS)
        ) u_cell (
            .clk      (clk),
            .cmd      (cmds[i]),
            .wr_id    (wr_id),
            .wr_key   (wr_key),
            .wr_kv    (wr_kv),
            .nb_id    (nb_ids[i]),
            .nb_key   (nb_keys[i]),
            .nb_kv    (nb_kvs[i]),
            .occupied (CNT_BITS'(i) < count_reg),
            .cmp_id   (cmp_id),
            .cmp_key  (cmp_key),
            .id_out   (ids[i]),
            .key_out  (keys[i]),
            .kv_out   (kvs[i]),
            .key_hit  (key_hit[i]),
            .id_hit   (id_hit[i])
        );
    end

endmodule

>>> design/priority_command_queue_coalescing_top.sv
`timescale 1ns / 1ps
// Strict-priority command queue, one FIFO of LEVEL_DEPTH ticket slots per level for NUM_LEVELS
// levels, each level a chain of slot cells that shift toward the head on removal. One request is
// taken at a time: a request is accepted only while no result is pending, is decided in the
// following cycle and its result goes out through an output register. A keyed takeover gives
// a second result after the first, and stop-only begin or a running shutdown sweeps the lower
// levels one by one, giving one result per discarded entry and a closing ack. Key and ticket
// searches compare all slots in parallel; the level-by-level discard sweep sets the length of
// the long requests.
module priority_command_queue_coalescing_top
    import pcq_pkg::*;
#(
    parameter int NUM_LEVELS  = 3,
    parameter int LEVEL_DEPTH = 8,
    parameter int TICKET_BITS = 16,
    parameter int KEY_BITS    = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  action,
    input  logic [1:0]  priority_req,
    input  logic        has_key,
    input  logic [15:0] coalesce_key,
    input  logic [15:0] command_id,
    input  logic        succeeded,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  event_res,
    output logic [15:0] item_id,
    output logic        last
);

    localparam int CNT_BITS  = $clog2(LEVEL_DEPTH + 1);
    localparam int POS_BITS  = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int LVL_BITS  = $clog2(NUM_LEVELS);
    localparam int DLVL_BITS = $clog2(NUM_LEVELS + 1);
    localparam int CMP_BITS  = (TICKET_BITS > 16) ? TICKET_BITS : 16;
    localparam logic [TICKET_BITS-1:0] TICKET_ONE = TICKET_BITS'(1);

    state_t                 state_reg, state_next;
    logic [3:0]             req_act_reg;
    logic [1:0]             req_lvl_reg;
    logic                   req_has_key_reg;
    logic [KEY_BITS-1:0]    req_key_reg;
    logic [15:0]            req_id_reg;
    logic                   req_succ_reg;

    logic                   accepting_reg, accepting_next;
    logic                   stop_only_reg, stop_only_next;
    logic                   shutdown_reg, shutdown_next;
    logic                   running_reg, running_next;
    logic [TICKET_BITS-1:0] active_reg, active_next;
    logic [TICKET_BITS-1:0] barrier_reg, barrier_next;
    logic [TICKET_BITS-1:0] next_ticket_reg, next_ticket_next;
    logic [TICKET_BITS-1:0] pend_ticket_reg, pend_ticket_next;
    logic [DLVL_BITS-1:0]   drain_lvl_reg, drain_lvl_next;
    logic [3:0]             drain_ev_reg, drain_ev_next;

    logic                   out_valid_reg, out_valid_next;
    logic [3:0]             ev_reg, ev_next;
    logic [15:0]            id_reg, id_next;
    logic                   last_reg, last_next;

    level_ctrl_t            lvl_ctrl    [NUM_LEVELS];
    logic [CNT_BITS-1:0]    lvl_count   [NUM_LEVELS];
    logic [TICKET_BITS-1:0] lvl_ids     [NUM_LEVELS][LEVEL_DEPTH];
    logic [LEVEL_DEPTH-1:0] lvl_key_hit [NUM_LEVELS];
    logic [LEVEL_DEPTH-1:0] lvl_id_hit  [NUM_LEVELS];

    logic [POS_BITS-1:0]    key_pos [NUM_LEVELS];
    logic [POS_BITS-1:0]    id_pos  [NUM_LEVELS];
    logic                   key_any [NUM_LEVELS];
    logic                   id_any  [NUM_LEVELS];
    logic                   c_any, ne_any;
    logic [LVL_BITS-1:0]    c_lvl, ne_lvl, sub_lvl, d_lvl;
    logic                   lvl_ok, out_free, drain_done;
    logic [CMP_BITS-1:0]    cmp_id;
    logic [TICKET_BITS-1:0] tk_inc, tk_after;

    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign event_res  = ev_reg;
    assign item_id    = id_reg;
    assign last       = last_reg;
    assign out_free   = !out_valid_reg || !out_stall;
    assign cmp_id     = CMP_BITS'(req_id_reg);
    assign sub_lvl    = LVL_BITS'(req_lvl_reg);
    assign lvl_ok     = (int'(req_lvl_reg) < NUM_LEVELS);
    assign d_lvl      = drain_lvl_reg[LVL_BITS-1:0];
    assign drain_done = (drain_lvl_reg == DLVL_BITS'(NUM_LEVELS));
    assign tk_inc     = next_ticket_reg + TICKET_ONE;
    assign tk_after   = (tk_inc == '0) ? TICKET_ONE : tk_inc;

    for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_level
        pcq_level #(
            .LEVEL_DEPTH (LEVEL_DEPTH),
            .TICKET_BITS (TICKET_BITS),
            .KEY_BITS    (KEY_BITS),
            .CMP_BITS    (CMP_BITS)
        ) u_level (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctrl    (lvl_ctrl[g]),
            .wr_id   (next_ticket_reg),
            .wr_key  (req_key_reg),
            .wr_kv   (req_has_key_reg),
            .cmp_id  (cmp_id),
            .cmp_key (req_key_reg),
            .count   (lvl_count[g]),
            .ids     (lvl_ids[g]),
            .key_hit (lvl_key_hit[g]),
            .id_hit  (lvl_id_hit[g])
        );
    end

    // oldest hit per level, then first level for cancel and dispatch
    always_comb
    begin
        c_any  = 1'b0;
        c_lvl  = '0;
        ne_any = 1'b0;
        ne_lvl = '0;
        for (int g = NUM_LEVELS - 1; g >= 0; g--)
        begin
            key_any[g] = |lvl_key_hit[g];
            id_any[g]  = |lvl_id_hit[g];
            key_pos[g] = '0;
            id_pos[g]  = '0;
            for (int i = LEVEL_DEPTH - 1; i >= 0; i--)
            begin
                if (lvl_key_hit[g][i])
                begin
                    key_pos[g] = POS_BITS'(i);
                end
                if (lvl_id_hit[g][i])
                begin
                    id_pos[g] = POS_BITS'(i);
                end
            end
            if (id_any[g])
            begin
                c_any = 1'b1;
                c_lvl = LVL_BITS'(g);
            end
            if (lvl_count[g] != '0)
            begin
                ne_any = 1'b1;
                ne_lvl = LVL_BITS'(g);
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        accepting_next   = accepting_reg;
        stop_only_next   = stop_only_reg;
        shutdown_next    = shutdown_reg;
        running_next     = running_reg;
        active_next      = active_reg;
        barrier_next     = barrier_reg;
        next_ticket_next = next_ticket_reg;
        pend_ticket_next = pend_ticket_reg;
        drain_lvl_next   = drain_lvl_reg;
        drain_ev_next    = drain_ev_reg;
        out_valid_next   = out_valid_reg && out_stall;
        ev_next          = ev_reg;
        id_next          = id_reg;
        last_next        = last_reg;
        for (int g = 0; g < NUM_LEVELS; g++)
        begin
            lvl_ctrl[g].op  = LOP_HOLD;
            lvl_ctrl[g].pos = '0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                out_valid_next = 1'b1;
                ev_next        = EV_REJECTED;
                id_next        = '0;
                last_next      = 1'b1;
                state_next     = S_WAIT;
                unique case (action_t'(req_act_reg))
                    ACT_START:
                    begin
                        if (!running_reg)
                        begin
                            for (int g = 0; g < NUM_LEVELS; g++)
                            begin
                                lvl_ctrl[g].op = LOP_CLEAR;
                            end
                            shutdown_next  = 1'b0;
                            active_next    = '0;
                            barrier_next   = '0;
                            accepting_next = 1'b1;
                            stop_only_next = 1'b0;
                            running_next   = 1'b1;
                        end
                        ev_next = EV_ACK;
                    end
                    ACT_SUBMIT:
                    begin
                        if (!lvl_ok || !accepting_reg || shutdown_reg ||
                            (req_lvl_reg != 2'd0 && (stop_only_reg || barrier_reg != '0)))
                        begin
                            ev_next = EV_REJECTED;
                        end
                        else if (req_has_key_reg && key_any[sub_lvl])
                        begin
                            lvl_ctrl[sub_lvl].op  = LOP_REPLACE;
                            lvl_ctrl[sub_lvl].pos = POS_FIELD_BITS'(key_pos[sub_lvl]);
                            ev_next          = EV_SUPERSEDED;
                            id_next          = 16'(lvl_ids[sub_lvl][key_pos[sub_lvl]]);
                            last_next        = 1'b0;
                            pend_ticket_next = next_ticket_reg;
                            next_ticket_next = tk_after;
                            state_next       = S_SECOND;
                        end
                        else if (lvl_count[sub_lvl] == CNT_BITS'(LEVEL_DEPTH))
                        begin
                            ev_next = EV_REJECTED;
                        end
                        else
                        begin
                            lvl_ctrl[sub_lvl].op = LOP_APPEND;
                            ev_next          = EV_ACCEPTED;
                            id_next          = 16'(next_ticket_reg);
                            next_ticket_next = tk_after;
                        end
                    end
                    ACT_CANCEL:
                    begin
                        id_next = req_id_reg;
                        if (req_id_reg != '0 && c_any)
                        begin
                            lvl_ctrl[c_lvl].op  = LOP_REMOVE;
                            lvl_ctrl[c_lvl].pos = POS_FIELD_BITS'(id_pos[c_lvl]);
                            ev_next = EV_CANCELLED;
                        end
                        else
                        begin
                            ev_next = EV_REJECTED;
                        end
                    end
                    ACT_DISPATCH:
                    begin
                        if (!running_reg)
                        begin
                            ev_next = EV_REJECTED;
                        end
                        else if (active_reg != '0)
                        begin
                            ev_next = EV_REJECTED;
                            id_next = 16'(active_reg);
                        end
                        else if (ne_any)
                        begin
                            lvl_ctrl[ne_lvl].op = LOP_REMOVE;
                            active_next = lvl_ids[ne_lvl][0];
                            ev_next     = EV_DISPATCHED;
                            id_next     = 16'(lvl_ids[ne_lvl][0]);
                        end
                        else if (shutdown_reg)
                        begin
                            running_next   = 1'b0;
                            accepting_next = 1'b0;
                            active_next    = '0;
                            barrier_next   = '0;
                            ev_next        = EV_WORKER_STOPPED;
                        end
                        else
                        begin
                            ev_next = EV_EMPTY;
                        end
                    end
                    ACT_FINISH:
                    begin
                        if (active_reg == '0)
                        begin
                            ev_next = EV_REJECTED;
                        end
                        else
                        begin
                            ev_next = req_succ_reg ? EV_SUCCEEDED : EV_FAILED;
                            id_next = 16'(active_reg);
                            if (barrier_reg == active_reg)
                            begin
                                barrier_next = '0;
                            end
                            active_next = '0;
                        end
                    end
                    ACT_MARK_TIMEOUT:
                    begin
                        id_next = req_id_reg;
                        if (req_id_reg != '0 && (CMP_BITS'(active_reg) == cmp_id || c_any))
                        begin
                            barrier_next = TICKET_BITS'(req_id_reg);
                            ev_next      = EV_ACK;
                        end
                        else
                        begin
                            ev_next = EV_REJECTED;
                        end
                    end
                    ACT_STOP_ON:
                    begin
                        stop_only_next = 1'b1;
                        out_valid_next = 1'b0;
                        drain_ev_next  = EV_CANCELLED;
                        drain_lvl_next = DLVL_BITS'(1);
                        state_next     = S_DRAIN;
                    end
                    ACT_STOP_OFF:
                    begin
                        if (accepting_reg && !shutdown_reg && barrier_reg == '0)
                        begin
                            stop_only_next = 1'b0;
                            ev_next        = EV_ACK;
                        end
                        else
                        begin
                            ev_next = EV_REJECTED;
                        end
                    end
                    ACT_SHUTDOWN:
                    begin
                        accepting_next = 1'b0;
                        ev_next        = EV_ACK;
                        if (running_reg)
                        begin
                            shutdown_next  = 1'b1;
                            out_valid_next = 1'b0;
                            drain_ev_next  = EV_SHUTDOWN_DISCARD;
                            drain_lvl_next = DLVL_BITS'(1);
                            state_next     = S_DRAIN;
                        end
                    end
                    default:
                    begin
                        ev_next = EV_REJECTED;
                    end
                endcase
            end
            S_SECOND:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    ev_next        = EV_ACCEPTED;
                    id_next        = 16'(pend_ticket_reg);
                    last_next      = 1'b1;
                    state_next     = S_WAIT;
                end
            end
            S_DRAIN:
            begin
                if (drain_done)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        ev_next        = EV_ACK;
                        id_next        = '0;
                        last_next      = 1'b1;
                        state_next     = S_WAIT;
                    end
                end
                else if (lvl_count[d_lvl] != '0)
                begin
                    if (out_free)
                    begin
                        lvl_ctrl[d_lvl].op = LOP_REMOVE;
                        out_valid_next = 1'b1;
                        ev_next        = drain_ev_reg;
                        id_next        = 16'(lvl_ids[d_lvl][0]);
                        last_next      = 1'b0;
                    end
                end
                else
                begin
                    drain_lvl_next = drain_lvl_reg + 1'b1;
                end
            end
            S_WAIT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            accepting_reg   <= 1'b0;
            stop_only_reg   <= 1'b0;
            shutdown_reg    <= 1'b0;
            running_reg     <= 1'b0;
            active_reg      <= '0;
            barrier_reg     <= '0;
            next_ticket_reg <= TICKET_ONE;
            drain_lvl_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            accepting_reg   <= accepting_next;
            stop_only_reg   <= stop_only_next;
            shutdown_reg    <= shutdown_next;
            running_reg     <= running_next;
            active_reg      <= active_next;
            barrier_reg     <= barrier_next;
            next_ticket_reg <= next_ticket_next;
            drain_lvl_reg   <= drain_lvl_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_ticket_reg <= pend_ticket_next;
        drain_ev_reg    <= drain_ev_next;
        ev_reg          <= ev_next;
        id_reg          <= id_next;
        last_reg        <= last_next;
        if (state_reg == S_IDLE && in_valid)
        begin
            req_act_reg     <= action;
            req_lvl_reg     <= priority_req;
            req_has_key_reg <= has_key;
            req_key_reg     <= KEY_BITS'(coalesce_key);
            req_id_reg      <= command_id;
            req_succ_reg    <= succeeded;
        end
    end

endmodule

>>> design/pcq_checker.sv
`timescale 1ns / 1ps
module pcq_checker
    import pcq_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [3:0]  event_res,
    input logic [15:0] item_id,
    input logic        last
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(event_res) && $stable(item_id)
            && $stable(last))
        else $error("stalled result changed");

    // one request at a time: nothing pending when a request is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> !out_valid)
        else $error("request taken while a result is pending");

    // a taken request blocks the input until its results are done
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second request taken too early");

    // empty and worker stop carry no ticket
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_res == EV_EMPTY || event_res == EV_WORKER_STOPPED)
            |-> item_id == 16'd0 && last)
        else $error("empty or worker stop with a ticket");

endmodule

bind priority_command_queue_coalescing_top pcq_checker u_pcq_checker (.*);

>>> dv/tb_priority_command_queue_coalescing_top.sv
`timescale 1ns / 1ps
module tb_priority_command_queue_coalescing_top;
    import pcq_pkg::*;

    localparam int LEVELS = 3;
    localparam int DEPTH  = 8;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [3:0]  ev;
        logic [15:0] id;
        logic        fin;
    } queue_event_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [3:0]  action;
    logic [1:0]  priority_req;
    logic        has_key;
    logic [15:0] coalesce_key;
    logic [15:0] command_id;
    logic        succeeded;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  event_res;
    logic [15:0] item_id;
    logic        last;

    priority_command_queue_coalescing_top uut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .action(action), .priority_req(priority_req), .has_key(has_key),
        .coalesce_key(coalesce_key), .command_id(command_id), .succeeded(succeeded),
        .out_valid(out_valid), .out_stall(out_stall), .event_res(event_res),
        .item_id(item_id), .last(last)
    );

    // predictor state
    logic [15:0] q_id [LEVELS][DEPTH];
    logic [15:0] q_key [LEVELS][DEPTH];
    logic        q_keyed [LEVELS][DEPTH];
    int          q_cnt [LEVELS];
    logic [15:0] ticket_next;
    logic [15:0] active_id;
    logic [15:0] barrier_id;
    logic        accepting;
    logic        stop_only;
    logic        shut;
    logic        running;

    queue_event_t expected_events[$];
    int  failures;
    int  cycles;
    bit  hold_off;
    int  hold_cycles;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic void push_event(logic [3:0] ev, logic [15:0] id);
        queue_event_t e;
        e.ev = ev;
        e.id = id;
        e.fin = 1'b0;
        expected_events.insert(expected_events.size(), e);
    endfunction

    function automatic void mark_last();
        queue_event_t e;
        int idx;
        idx = expected_events.size() - 1;
        e = expected_events[idx];
        e.fin = 1'b1;
        expected_events[idx] = e;
    endfunction

    function automatic logic [15:0] grab_ticket();
        logic [15:0] t;
        t = ticket_next;
        ticket_next = ticket_next + 16'd1;
        if (ticket_next == 16'd0)
            ticket_next = 16'd1;
        return t;
    endfunction

    function automatic void drop_slot(int lv, int pos);
        for (int i = pos; i + 1 < q_cnt[lv]; i++)
        begin
            q_id[lv][i] = q_id[lv][i+1];
            q_key[lv][i] = q_key[lv][i+1];
            q_keyed[lv][i] = q_keyed[lv][i+1];
        end
        q_cnt[lv]--;
    endfunction

    function automatic void flush_lower(logic [3:0] ev);
        for (int lv = 1; lv < LEVELS; lv++)
        begin
            for (int i = 0; i < q_cnt[lv]; i++)
                push_event(ev, q_id[lv][i]);
            q_cnt[lv] = 0;
        end
    endfunction

    function automatic bit locate(logic [15:0] id, output int lv_o, output int pos_o);
        lv_o = 0;
        pos_o = 0;
        for (int lv = 0; lv < LEVELS; lv++)
            for (int i = 0; i < q_cnt[lv]; i++)
                if (q_id[lv][i] == id)
                begin
                    lv_o = lv;
                    pos_o = i;
                    return 1'b1;
                end
        return 1'b0;
    endfunction

    function automatic void reset_queue_model();
        for (int lv = 0; lv < LEVELS; lv++)
            q_cnt[lv] = 0;
        ticket_next = 16'd1;
        active_id = '0;
        barrier_id = '0;
        accepting = 1'b0;
        stop_only = 1'b0;
        shut = 1'b0;
        running = 1'b0;
    endfunction

    function automatic void predict_queue(logic [3:0] act, logic [1:0] lvr, logic keyed,
                                          logic [15:0] key, logic [15:0] id, logic ok);
        int lv;
        int pos;
        bit done;
        logic [15:0] t;
        done = 1'b0;
        case (act)
            ACT_START:
            begin
                if (!running)
                begin
                    for (int l = 0; l < LEVELS; l++)
                        q_cnt[l] = 0;
                    shut = 1'b0;
                    active_id = '0;
                    barrier_id = '0;
                    accepting = 1'b1;
                    stop_only = 1'b0;
                    running = 1'b1;
                end
                push_event(EV_ACK, '0);
            end
            ACT_SUBMIT:
            begin
                lv = lvr;
                if (lv >= LEVELS || !accepting || shut ||
                    (lv != 0 && (stop_only || barrier_id != 0)))
                    push_event(EV_REJECTED, '0);
                else
                begin
                    if (keyed)
                        for (int i = 0; i < q_cnt[lv] && !done; i++)
                            if (q_keyed[lv][i] && q_key[lv][i] == key)
                            begin
                                t = grab_ticket();
                                push_event(EV_SUPERSEDED, q_id[lv][i]);
                                push_event(EV_ACCEPTED, t);
                                q_id[lv][i] = t;
                                done = 1'b1;
                            end
                    if (!done)
                    begin
                        if (q_cnt[lv] >= DEPTH)
                            push_event(EV_REJECTED, '0);
                        else
                        begin
                            t = grab_ticket();
                            q_id[lv][q_cnt[lv]] = t;
                            q_key[lv][q_cnt[lv]] = keyed ? key : '0;
                            q_keyed[lv][q_cnt[lv]] = keyed;
                            q_cnt[lv]++;
                            push_event(EV_ACCEPTED, t);
                        end
                    end
                end
            end
            ACT_CANCEL:
            begin
                if (id != 0 && locate(id, lv, pos))
                begin
                    drop_slot(lv, pos);
                    push_event(EV_CANCELLED, id);
                end
                else
                    push_event(EV_REJECTED, id);
            end
            ACT_DISPATCH:
            begin
                if (!running)
                    push_event(EV_REJECTED, '0);
                else if (active_id != 0)
                    push_event(EV_REJECTED, active_id);
                else
                begin
                    lv = 0;
                    while (lv < LEVELS && q_cnt[lv] == 0)
                        lv++;
                    if (lv < LEVELS)
                    begin
                        active_id = q_id[lv][0];
                        drop_slot(lv, 0);
                        push_event(EV_DISPATCHED, active_id);
                    end
                    else if (shut)
                    begin
                        running = 1'b0;
                        accepting = 1'b0;
                        active_id = '0;
                        barrier_id = '0;
                        push_event(EV_WORKER_STOPPED, '0);
                    end
                    else
                        push_event(EV_EMPTY, '0);
                end
            end
            ACT_FINISH:
            begin
                if (active_id == 0)
                    push_event(EV_REJECTED, '0);
                else
                begin
                    push_event(ok ? EV_SUCCEEDED : EV_FAILED, active_id);
                    if (barrier_id == active_id)
                        barrier_id = '0;
                    active_id = '0;
                end
            end
            ACT_MARK_TIMEOUT:
            begin
                if (id != 0 && (active_id == id || locate(id, lv, pos)))
                begin
                    barrier_id = id;
                    push_event(EV_ACK, id);
                end
                else
                    push_event(EV_REJECTED, id);
            end
            ACT_STOP_ON:
            begin
                stop_only = 1'b1;
                flush_lower(EV_CANCELLED);
                push_event(EV_ACK, '0);
            end
            ACT_STOP_OFF:
            begin
                if (accepting && !shut && barrier_id == 0)
                begin
                    stop_only = 1'b0;
                    push_event(EV_ACK, '0);
                end
                else
                    push_event(EV_REJECTED, '0);
            end
            ACT_SHUTDOWN:
            begin
                accepting = 1'b0;
                if (running)
                begin
                    shut = 1'b1;
                    flush_lower(EV_SHUTDOWN_DISCARD);
                end
                push_event(EV_ACK, '0);
            end
            default:
                push_event(EV_REJECTED, '0);
        endcase
        mark_last();
    endfunction

    task automatic send_request(logic [3:0] act, logic [1:0] lvr = 2'd1, logic keyed = 1'b0,
                                logic [15:0] key = '0, logic [15:0] id = '0,
                                logic ok = 1'b1);
        int gap;
        gap = $urandom_range(0, 5);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        priority_req <= lvr;
        has_key <= keyed;
        coalesce_key <= key;
        command_id <= id;
        succeeded <= ok;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_queue(act, lvr, keyed, key, id, ok);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_events.size() != 0)
            @(posedge clk);
    endtask

    // receiver stall and result checking
    always @(posedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            hold_cycles <= $urandom_range(0, 5) * ($urandom_range(0, 3) != 0);
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        queue_event_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_events.size() == 0)
            begin
                $error("unexpected result event_res=%0d item_id=%0d", event_res, item_id);
                failures++;
            end
            else
            begin
                e = expected_events[0];
                expected_events.delete(0);
                if (event_res !== e.ev)
                begin
                    $error("event_res expected %0d actual %0d", e.ev, event_res);
                    failures++;
                end
                if (item_id !== e.id)
                begin
                    $error("item_id expected %0d actual %0d", e.id, item_id);
                    failures++;
                end
                if (last !== e.fin)
                begin
                    $error("last expected %0d actual %0d", e.fin, last);
                    failures++;
                end
            end
        end
    end

    task automatic test_lifecycle();
        send_request(ACT_DISPATCH);
        send_request(ACT_SUBMIT, 2'd0);
        send_request(ACT_START);
        send_request(ACT_START);
        send_request(ACT_DISPATCH);
        send_request(ACT_FINISH);
        send_request(ACT_SUBMIT, 2'd3, 1'b1, 16'hFFFF);
        send_request(4'd15, 2'd3, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1);
        send_request(4'd9);
    endtask

    task automatic test_coalescing();
        send_request(ACT_SUBMIT, 2'd1, 1'b1, 16'hFFFF);
        send_request(ACT_SUBMIT, 2'd1, 1'b0, 16'hFFFF);
        send_request(ACT_SUBMIT, 2'd1, 1'b1, 16'hFFFF);
        send_request(ACT_SUBMIT, 2'd1, 1'b1, 16'h0000);
        send_request(ACT_SUBMIT, 2'd2, 1'b1, 16'hFFFF);
        for (int i = 0; i < 6; i++)
            send_request(ACT_SUBMIT, 2'd1);
        send_request(ACT_SUBMIT, 2'd1, 1'b1, 16'hFFFF);
        send_request(ACT_CANCEL, 2'd0, 1'b0, '0, 16'd0);
        send_request(ACT_CANCEL, 2'd0, 1'b0, '0, 16'd3);
        send_request(ACT_CANCEL, 2'd0, 1'b0, '0, 16'hFFFF);
    endtask

    task automatic test_dispatch_and_barrier();
        send_request(ACT_SUBMIT, 2'd0);
        send_request(ACT_DISPATCH);
        send_request(ACT_DISPATCH);
        send_request(ACT_MARK_TIMEOUT, 2'd0, 1'b0, '0, active_id);
        send_request(ACT_SUBMIT, 2'd2);
        send_request(ACT_STOP_OFF);
        send_request(ACT_MARK_TIMEOUT, 2'd0, 1'b0, '0, 16'd0);
        send_request(ACT_FINISH, 2'd0, 1'b0, '0, '0, 1'b0);
        send_request(ACT_STOP_ON);
        send_request(ACT_SUBMIT, 2'd1);
        send_request(ACT_STOP_OFF);
    endtask

    task automatic test_shutdown();
        send_request(ACT_SUBMIT, 2'd0);
        send_request(ACT_SUBMIT, 2'd1);
        send_request(ACT_SUBMIT, 2'd2);
        send_request(ACT_SHUTDOWN);
        send_request(ACT_STOP_OFF);
        send_request(ACT_DISPATCH);
        send_request(ACT_FINISH);
        send_request(ACT_DISPATCH);
        send_request(ACT_SHUTDOWN);
        send_request(ACT_START);
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                for (int i = 0; i < 10; i++)
                    send_request(ACT_SUBMIT, 2'($urandom_range(1, 2)));
                send_request(ACT_STOP_ON);
            end
            begin
                repeat (60) @(posedge clk);
                hold_off = 1'b0;
            end
        join
        wait_drained();
        send_request(ACT_STOP_OFF);
    endtask

    function automatic logic [15:0] pick_id();
        int lv;
        if ($urandom_range(0, 3) == 0 || (q_cnt[0] + q_cnt[1] + q_cnt[2]) == 0)
            return 16'($urandom_range(0, 65535) & (($urandom_range(0, 1)) ? 16'hFFFF : 16'h1F));
        do lv = $urandom_range(0, LEVELS - 1); while (q_cnt[lv] == 0);
        return q_id[lv][$urandom_range(0, q_cnt[lv] - 1)];
    endfunction

    task automatic test_random_traffic();
        int r;
        logic [3:0] act;
        for (int n = 0; n < 75; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40) act = ACT_SUBMIT;
            else if (r < 50) act = ACT_CANCEL;
            else if (r < 62) act = ACT_DISPATCH;
            else if (r < 74) act = ACT_FINISH;
            else if (r < 80) act = ACT_MARK_TIMEOUT;
            else if (r < 84) act = ACT_STOP_ON;
            else if (r < 89) act = ACT_STOP_OFF;
            else if (r < 92) act = ACT_SHUTDOWN;
            else if (r < 97) act = ACT_START;
            else act = 4'($urandom_range(9, 15));
            if (!running && $urandom_range(0, 1))
                act = ACT_START;
            send_request(act, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                         ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                             16'($urandom_range(0, 3)),
                         pick_id(), 1'($urandom_range(0, 1)));
            if (n == 37)
                wait_drained();
        end
    endtask

    initial
    begin
        failures = 0;
        cycles = 0;
        hold_off = 1'b0;
        hold_cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        action = '0;
        priority_req = '0;
        has_key = 1'b0;
        coalesce_key = '0;
        command_id = '0;
        succeeded = 1'b0;
        reset_queue_model();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_lifecycle();
        test_coalescing();
        test_dispatch_and_barrier();
        test_shutdown();
        test_backpressure();
        test_random_traffic();
        wait_drained();
        repeat (40) @(posedge clk);
        if (failures == 0 && expected_events.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
